@@ rtl/pvbca_pkg.sv @@
// Shared constants for the per-vertex budget cut admission block.
package pvbca_pkg;

    // Default sizes
    localparam int NUM_VERTICES_DEF     = 256;
    localparam int MAX_REFS_PER_CUT_DEF = 32;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int VERTEX_W = 8;
    localparam int BUDGET_W = 8;

    // Reset value of the budget limit register
    localparam logic [BUDGET_W-1:0] BUDGET_LIMIT_RESET = 8'd15;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_START    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXISTING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CAND     = 2'd2;

    // Result kinds
    localparam logic KIND_EXISTING = 1'b0;
    localparam logic KIND_CAND     = 1'b1;

endpackage

@@ rtl/pvbca_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pvbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/per_vertex_budget_cut_admission.sv @@
// Top level of the per-vertex budget cut admission block.
//
// Usage:
//   Requests enter on start/mode/vertex/last_ref and are accepted at a clock
//   edge with start high and busy low. Mode 0 refills every vertex budget to
//   the budget limit, mode 1 charges one reference of an existing cut, mode 2
//   tentatively charges one reference of a candidate cut, mode 3 is dropped.
//   The user writes the budget limit through cfg_we/cfg_data while the block idles.
//   A request with last_ref set on mode 1 or 2 yields one result, shown on
//   cut_kind/cut_kept/budget_error for exactly one cycle with result_valid.
//   The receiver cannot stall: every result is taken the cycle it appears.
// Sequence:
//   A reference has its budget read from the budget RAM as it is accepted,
//   then checked and, if it passes, written back in S_EXEC, where its result,
//   if any, is registered. A rejected candidate with charges to undo first
//   walks its pending list: for each pending reference a pending RAM read, a
//   budget read and a write. A start sweeps the budget RAM one entry per cycle.
// Reset:
//   Reset clears the control state and runs the same sweep, busy high, with
//   the reset limit of 15. The block itself does not hold off limit writes:
//   they are taken during the sweep too and apply from the next start on.
module per_vertex_budget_cut_admission #(
    parameter int NUM_VERTICES     = pvbca_pkg::NUM_VERTICES_DEF,
    parameter int MAX_REFS_PER_CUT = pvbca_pkg::MAX_REFS_PER_CUT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic [pvbca_pkg::MODE_W-1:0]   mode,
    input  logic [pvbca_pkg::VERTEX_W-1:0] vertex,
    input  logic                           last_ref,
    // budget limit register
    input  logic                           cfg_we,
    input  logic [pvbca_pkg::BUDGET_W-1:0] cfg_data,
    // result channel
    output logic                           result_valid,
    output logic                           cut_kind,
    output logic                           cut_kept,
    output logic                           budget_error
);

    import pvbca_pkg::*;

    localparam int AW  = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int PAW = (MAX_REFS_PER_CUT > 1) ? $clog2(MAX_REFS_PER_CUT) : 1;
    localparam int CW  = $clog2(MAX_REFS_PER_CUT + 1);
    localparam int XW  = AW + VERTEX_W;

    typedef enum logic [5:0] {
        S_SWEEP  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_UNDO_P = 6'b001000,
        S_UNDO_B = 6'b010000,
        S_UNDO_W = 6'b100000
    } state_t;

    // Zero-extend a vertex index and keep the address bits.
    function automatic logic [AW-1:0] to_addr(input logic [VERTEX_W-1:0] v);
        logic [XW-1:0] w;
        w = {{AW{1'b0}}, v};
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [VERTEX_W-1:0] v);
        logic [XW-1:0] w;
        w = {{AW{1'b0}}, v};
        return w < XW'(NUM_VERTICES);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg,      state_next;
    logic [BUDGET_W-1:0]   limit_reg,      limit_next;
    logic [BUDGET_W-1:0]   fill_reg,       fill_next;
    logic [AW-1:0]         sweep_cnt_reg,  sweep_cnt_next;
    logic                  is_cand_reg,    is_cand_next;
    logic                  in_range_reg,   in_range_next;
    logic                  last_reg,       last_next;
    logic [AW-1:0]         addr_reg,       addr_next;
    logic [VERTEX_W-1:0]   vertex_reg,     vertex_next;
    logic [CW-1:0]         pend_cnt_reg,   pend_cnt_next;
    logic                  rejected_reg,   rejected_next;
    logic                  overdraw_reg,   overdraw_next;
    logic [CW-1:0]         walk_idx_reg,   walk_idx_next;
    logic [AW-1:0]         undo_addr_reg,  undo_addr_next;
    logic                  res_valid_reg,  res_valid_next;
    logic                  res_kind_reg,   res_kind_next;
    logic                  res_kept_reg,   res_kept_next;
    logic                  res_err_reg,    res_err_next;

    // RAM ports
    logic                  bud_we;
    logic [AW-1:0]         bud_waddr;
    logic [BUDGET_W-1:0]   bud_wdata;
    logic                  bud_re;
    logic [AW-1:0]         bud_raddr;
    logic [BUDGET_W-1:0]   bud_rdata;

    logic                  pend_we;
    logic [PAW-1:0]        pend_waddr;
    logic                  pend_re;
    logic [PAW-1:0]        pend_raddr;
    logic [VERTEX_W-1:0]   pend_rdata;

    logic                  accept;
    logic                  budget_ok;
    logic [CW-1:0]         walk_idx_inc;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign budget_ok    = in_range_reg && (bud_rdata != '0);
    assign walk_idx_inc = walk_idx_reg + CW'(1);

    // ------------------------------------------------------------------
    // Memories: budget per vertex, pending list of the open candidate
    // ------------------------------------------------------------------
    pvbca_ram #(
        .WIDTH (BUDGET_W),
        .DEPTH (NUM_VERTICES)
    ) u_budget_ram (
        .clk   (clk),
        .we    (bud_we),
        .waddr (bud_waddr),
        .wdata (bud_wdata),
        .re    (bud_re),
        .raddr (bud_raddr),
        .rdata (bud_rdata)
    );

    pvbca_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_REFS_PER_CUT)
    ) u_pending_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (vertex_reg),
        .re    (pend_re),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        limit_next     = cfg_we ? cfg_data : limit_reg;
        fill_next      = fill_reg;
        sweep_cnt_next = sweep_cnt_reg;
        is_cand_next   = is_cand_reg;
        in_range_next  = in_range_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        vertex_next    = vertex_reg;
        pend_cnt_next  = pend_cnt_reg;
        rejected_next  = rejected_reg;
        overdraw_next  = overdraw_reg;
        walk_idx_next  = walk_idx_reg;
        undo_addr_next = undo_addr_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        res_kept_next  = res_kept_reg;
        res_err_next   = res_err_reg;

        bud_we     = 1'b0;
        bud_waddr  = addr_reg;
        bud_wdata  = bud_rdata - BUDGET_W'(1);
        bud_re     = 1'b0;
        bud_raddr  = to_addr(vertex);
        pend_we    = 1'b0;
        pend_waddr = pend_cnt_reg[PAW-1:0];
        pend_re    = 1'b0;
        pend_raddr = walk_idx_reg[PAW-1:0];

        case (state_reg)
            S_SWEEP:
            begin
                // refill one entry per cycle
                bud_we    = 1'b1;
                bud_waddr = sweep_cnt_reg;
                bud_wdata = fill_reg;
                if (sweep_cnt_reg == AW'(NUM_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_START:
                        begin
                            // drop any open candidate, refill all budgets
                            fill_next      = limit_reg;
                            sweep_cnt_next = '0;
                            pend_cnt_next  = '0;
                            rejected_next  = 1'b0;
                            state_next     = S_SWEEP;
                        end
                        MODE_EXISTING, MODE_CAND:
                        begin
                            bud_re        = in_range(vertex);
                            is_cand_next  = (mode == MODE_CAND);
                            in_range_next = in_range(vertex);
                            last_next     = last_ref;
                            addr_next     = to_addr(vertex);
                            vertex_next   = vertex;
                            state_next    = S_EXEC;
                        end
                        default:
                        begin
                            // unused mode: drop the request
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (!is_cand_reg)
                begin
                    if (budget_ok)
                    begin
                        bud_we = 1'b1;
                    end
                    else
                    begin
                        overdraw_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_EXISTING;
                        res_kept_next  = 1'b0;
                        res_err_next   = overdraw_next;
                    end
                end
                else
                begin
                    if (!rejected_reg)
                    begin
                        if (!budget_ok || pend_cnt_reg >= CW'(MAX_REFS_PER_CUT))
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            bud_we        = 1'b1;
                            pend_we       = 1'b1;
                            pend_cnt_next = pend_cnt_reg + CW'(1);
                        end
                    end
                    if (last_reg)
                    begin
                        res_kind_next = KIND_CAND;
                        res_err_next  = overdraw_reg;
                        if (!rejected_next)
                        begin
                            // admit: keep the charges
                            res_valid_next = 1'b1;
                            res_kept_next  = 1'b1;
                            pend_cnt_next  = '0;
                            rejected_next  = 1'b0;
                        end
                        else if (pend_cnt_next == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_kept_next  = 1'b0;
                            rejected_next  = 1'b0;
                        end
                        else
                        begin
                            // reject: give back every pending charge
                            walk_idx_next = '0;
                            state_next    = S_UNDO_P;
                        end
                    end
                end
            end

            S_UNDO_P:
            begin
                pend_re    = 1'b1;
                state_next = S_UNDO_B;
            end

            S_UNDO_B:
            begin
                bud_re         = 1'b1;
                bud_raddr      = to_addr(pend_rdata);
                undo_addr_next = to_addr(pend_rdata);
                state_next     = S_UNDO_W;
            end

            S_UNDO_W:
            begin
                bud_we    = 1'b1;
                bud_waddr = undo_addr_reg;
                bud_wdata = (bud_rdata == '1) ? bud_rdata : bud_rdata + BUDGET_W'(1);
                if (walk_idx_inc == pend_cnt_reg)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = KIND_CAND;
                    res_kept_next  = 1'b0;
                    res_err_next   = overdraw_reg;
                    pend_cnt_next  = '0;
                    rejected_next  = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    walk_idx_next = walk_idx_inc;
                    state_next    = S_UNDO_P;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            limit_reg     <= BUDGET_LIMIT_RESET;
            fill_reg      <= BUDGET_LIMIT_RESET;
            sweep_cnt_reg <= '0;
            pend_cnt_reg  <= '0;
            rejected_reg  <= 1'b0;
            overdraw_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            fill_reg      <= fill_next;
            sweep_cnt_reg <= sweep_cnt_next;
            pend_cnt_reg  <= pend_cnt_next;
            rejected_reg  <= rejected_next;
            overdraw_reg  <= overdraw_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: hold the latched request and the result fields
    always_ff @(posedge clk)
    begin
        is_cand_reg   <= is_cand_next;
        in_range_reg  <= in_range_next;
        last_reg      <= last_next;
        addr_reg      <= addr_next;
        vertex_reg    <= vertex_next;
        walk_idx_reg  <= walk_idx_next;
        undo_addr_reg <= undo_addr_next;
        res_kind_reg  <= res_kind_next;
        res_kept_reg  <= res_kept_next;
        res_err_reg   <= res_err_next;
    end

    assign result_valid = res_valid_reg;
    assign cut_kind     = res_kind_reg;
    assign cut_kept     = res_kept_reg;
    assign budget_error = res_err_reg;

`ifndef SYNTH
    // The overdraw error is sticky until reset.
    a_overdraw_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overdraw_reg |=> overdraw_reg)
        else $error("overdraw flag cleared without reset");

    // The pending list never holds more than its depth.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= CW'(MAX_REFS_PER_CUT))
        else $error("pending count beyond list depth");

    // Budget RAM reads and writes never share a cycle.
    a_bud_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        !(bud_we && bud_re))
        else $error("budget RAM read and write in the same cycle");

    // A result follows only the check cycle or the last undo step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_UNDO_W))
        else $error("result strobe from an unexpected state");
`endif

endmodule

@@ verif/per_vertex_budget_cut_admission_test.sv @@
// Self-checking testbench for the per-vertex budget cut admission block.
module per_vertex_budget_cut_admission_test;

    import pvbca_pkg::*;

    // Mode 3 has no name in the package; the block must drop it.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    localparam int QUIET_CYCLES   = 400;   // covers a full refill sweep plus an undo walk
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request and no result taken
    localparam int MAX_REPORTS    = 10;

    // One result as the block reports it.
    typedef struct packed {
        logic kind;
        logic kept;
        logic err;
    } cut_verdict_t;

    // Budget bookkeeping: mirrors the per-vertex counters, the open candidate
    // cut and the sticky overdraw flag, and queues the verdicts they imply.
    class cut_budget_book;
        logic [BUDGET_W-1:0] vertex_budget [NUM_VERTICES_DEF];
        logic [BUDGET_W-1:0] limit;
        logic [VERTEX_W-1:0] charged_vertices [$];
        bit                  cut_rejected;
        bit                  overdraw;
        cut_verdict_t        awaited_verdicts [$];
        int                  failures;

        function new();
            limit = BUDGET_LIMIT_RESET;
            foreach (vertex_budget[i])
                vertex_budget[i] = BUDGET_LIMIT_RESET;
            cut_rejected = 1'b0;
            overdraw     = 1'b0;
            failures     = 0;
        endfunction

        function void write_limit(input logic [BUDGET_W-1:0] value);
            limit = value;
        endfunction

        function void note_request(input logic [MODE_W-1:0] m,
                                   input logic [VERTEX_W-1:0] v,
                                   input logic l);
            logic kept;
            case (m)
                MODE_START:
                begin
                    foreach (vertex_budget[i])
                        vertex_budget[i] = limit;
                    charged_vertices.delete();
                    cut_rejected = 1'b0;
                end
                MODE_EXISTING:
                begin
                    // Every vertex index fits the table, so only an empty
                    // counter can overdraw.
                    if (vertex_budget[v] != '0)
                        vertex_budget[v] = vertex_budget[v] - 1'b1;
                    else
                        overdraw = 1'b1;
                    if (l)
                        awaited_verdicts.push_back('{kind: KIND_EXISTING, kept: 1'b0,
                                                     err: overdraw});
                end
                MODE_CAND:
                begin
                    if (!cut_rejected)
                    begin
                        if (vertex_budget[v] == '0 ||
                            charged_vertices.size() >= MAX_REFS_PER_CUT_DEF)
                            cut_rejected = 1'b1;
                        else
                        begin
                            vertex_budget[v] = vertex_budget[v] - 1'b1;
                            charged_vertices.push_back(v);
                        end
                    end
                    if (l)
                    begin
                        kept = !cut_rejected;
                        if (!kept)
                            foreach (charged_vertices[i])
                                if (vertex_budget[charged_vertices[i]] != '1)
                                    vertex_budget[charged_vertices[i]] =
                                        vertex_budget[charged_vertices[i]] + 1'b1;
                        charged_vertices.delete();
                        cut_rejected = 1'b0;
                        awaited_verdicts.push_back('{kind: KIND_CAND, kept: kept,
                                                     err: overdraw});
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input logic kind, input logic kept, input logic err);
            cut_verdict_t exp_v;
            if (awaited_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: kind %0d kept %0d error %0d",
                             kind, kept, err);
                return;
            end
            exp_v = awaited_verdicts.pop_front();
            if (exp_v.kind !== kind || exp_v.kept !== kept || exp_v.err !== err)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result mismatch: expected kind %0d kept %0d error %0d, got kind %0d kept %0d error %0d",
                             exp_v.kind, exp_v.kept, exp_v.err, kind, kept, err);
            end
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic [MODE_W-1:0]   mode         = MODE_START;
    logic [VERTEX_W-1:0] vertex       = '0;
    logic                last_ref     = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [BUDGET_W-1:0] cfg_data     = '0;
    logic                busy;
    logic                result_valid;
    logic                cut_kind;
    logic                cut_kept;
    logic                budget_error;

    cut_budget_book book = new();
    int             idle_pct      = 0;   // chance in percent of a gap before each request
    int             counted_reqs  = 0;   // requests that the block acts on
    int             stall_cycles  = 0;

    per_vertex_budget_cut_admission #(
        .NUM_VERTICES     (NUM_VERTICES_DEF),
        .MAX_REFS_PER_CUT (MAX_REFS_PER_CUT_DEF)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .vertex       (vertex),
        .last_ref     (last_ref),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .cut_kind     (cut_kind),
        .cut_kept     (cut_kept),
        .budget_error (budget_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check every strobed result at the edge that ends its cycle, and track
    // how long the block has gone without taking a request or giving a result.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            book.check_result(cut_kind, cut_kept, budget_error);
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Abort a hung run.
    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("per_vertex_budget_cut_admission_test: FAIL");
        $finish;
    end

    // Present one request and hold it until the block takes it. Before it, at
    // the phase's idle rate, drop start for a random gap and drive junk on
    // the fields meanwhile, which the block must ignore.
    task automatic send_req(input logic [MODE_W-1:0] m, input logic [VERTEX_W-1:0] v,
                            input logic l);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            start    <= 1'b0;
            mode     <= MODE_W'($urandom);
            vertex   <= VERTEX_W'($urandom);
            last_ref <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        vertex   <= v;
        last_ref <= l;
        do @(posedge clk); while (busy);
        book.note_request(m, v, l);
        if (m != MODE_IGNORED)
            counted_reqs++;
    endtask

    // Write the budget limit; the block applies it from the next refill on.
    task automatic write_limit(input logic [BUDGET_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        book.write_limit(value);
    endtask

    // Drop start, wait for every awaited result, then give any work that
    // yields no result (a refill sweep) time to finish.
    task automatic settle();
        start <= 1'b0;
        while (book.awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Favor a handful of hot vertices so that budgets run dry.
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        if ($urandom_range(99) < 70)
            return VERTEX_W'($urandom_range(7));
        return VERTEX_W'($urandom_range(255));
    endfunction

    task automatic run_existing_cut();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_req(MODE_EXISTING, pick_vertex(), i == n - 1);
    endtask

    // Mostly short candidate cuts, some long enough to overflow the pending
    // list; stray existing references and a refill that drops the open cut
    // break in now and then.
    task automatic run_candidate_cut();
        int n;
        n = ($urandom_range(99) < 15) ? $urandom_range(28, 36) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(99) < 8)
                send_req(MODE_EXISTING, pick_vertex(), 1'($urandom));
            if (i > 0 && $urandom_range(99) < 3)
            begin
                send_req(MODE_START, pick_vertex(), 1'($urandom));
                return;
            end
            send_req(MODE_CAND, pick_vertex(), i == n - 1);
        end
    endtask

    task automatic run_random(input int n);
        int target;
        int pick;
        target = counted_reqs + n;
        send_req(MODE_START, VERTEX_W'($urandom), 1'($urandom));
        while (counted_reqs < target)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_req(MODE_START, VERTEX_W'($urandom), 1'($urandom));
            else if (pick < 10)
                send_req(MODE_IGNORED, VERTEX_W'($urandom), 1'($urandom));
            else if (pick < 45)
                run_existing_cut();
            else
                run_candidate_cut();
        end
    endtask

    // Write a limit while the block idles, then run a random phase.
    task automatic run_phase(input logic [BUDGET_W-1:0] lim, input int pct, input int n);
        settle();
        write_limit(lim);
        idle_pct = pct;
        run_random(n);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The limit write lands during the reset sweep, so the
        // first reference still sees the reset budget of 15.
        write_limit(8'd2);
        send_req(MODE_EXISTING, 8'd0, 1'b1);
        send_req(MODE_START, 8'd0, 1'b1);            // refill, no result even with last_ref
        send_req(MODE_IGNORED, 8'd255, 1'b1);        // unused mode, dropped
        // Drain one vertex inside a cut: third reference fails, undo the rest.
        send_req(MODE_CAND, 8'd255, 1'b0);
        send_req(MODE_CAND, 8'd255, 1'b0);
        send_req(MODE_CAND, 8'd255, 1'b1);
        // A clean two-vertex candidate is admitted.
        send_req(MODE_CAND, 8'd1, 1'b0);
        send_req(MODE_CAND, 8'd2, 1'b1);
        // Existing reference inside an open candidate, then a failed
        // reference and one after it that must charge nothing.
        send_req(MODE_CAND, 8'd1, 1'b0);
        send_req(MODE_EXISTING, 8'd3, 1'b1);
        send_req(MODE_CAND, 8'd1, 1'b0);
        send_req(MODE_CAND, 8'd4, 1'b1);
        // Refill drops the open candidate without a result.
        send_req(MODE_CAND, 8'd5, 1'b0);
        send_req(MODE_START, 8'd170, 1'b0);
        // Overdraw an existing cut; the error then sticks.
        send_req(MODE_EXISTING, 8'd128, 1'b0);
        send_req(MODE_EXISTING, 8'd128, 1'b0);
        send_req(MODE_EXISTING, 8'd128, 1'b1);
        send_req(MODE_CAND, 8'd127, 1'b1);
        send_req(MODE_START, 8'd85, 1'b1);           // a refill does not clear the error
        send_req(MODE_EXISTING, 8'd128, 1'b1);

        // Random part over several limits and idle rates.
        run_phase(8'd0, 0, 200);
        run_phase(8'd255, 60, 350);
        run_phase(8'd3, 0, 400);
        run_phase(BUDGET_W'($urandom_range(1, 6)), 14, 400);
        run_phase(8'd15, 60, 250);
        run_phase(8'd1, 0, 200);
        settle();

        if (book.awaited_verdicts.size() != 0)
            $display("%0d results never arrived", book.awaited_verdicts.size());
        if (book.failures == 0 && book.awaited_verdicts.size() == 0)
            $display("per_vertex_budget_cut_admission_test: PASS");
        else
            $display("per_vertex_budget_cut_admission_test: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pvbca_pkg.sv
rtl/pvbca_ram.sv
rtl/per_vertex_budget_cut_admission.sv
verif/per_vertex_budget_cut_admission_test.sv
